/* hw/rtl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the I2C master byte engine
// Transfer payloads, the classified command that crosses the queue, the
// register indexes and the command codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // Command codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_CYCLES_PER_US = 2'd0;
  localparam logic [1:0] CFG_SHORT_DELAY   = 2'd1;
  localparam logic [1:0] CFG_LONG_DELAY    = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // Register reset values
  localparam logic [9:0] CYCLES_PER_US_RST = 10'd50;
  localparam logic [7:0] SHORT_DELAY_RST   = 8'd2;
  localparam logic [7:0] LONG_DELAY_RST    = 8'd5;

  // One input transfer: one bus clock cycle worth of stimulus
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] op;
    logic [7:0] wr_data;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  // One result transfer: bus levels and status after that cycle
  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       ack_received;
  } out_item_t;

  // Item after the front end has decoded it
  typedef struct packed {
    logic       launch;     // command offered
    logic [1:0] op;
    logic [7:0] wr_data;
    logic       send_ack;
    logic       sda_in;
    logic       first_sda;  // SDA level driven when the command launches
  } cmd_t;

  // Timing registers
  typedef struct packed {
    logic [9:0] cycles_per_us;
    logic [7:0] short_delay_us;
    logic [7:0] long_delay_us;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/i2cm_chan_if.sv */
// ----------------------------------------------------------------------------
// i2cm_chan_if: valid/ready channel
// Carries one payload of type T per transfer; a transfer completes at a
// rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/i2cm_front.sv */
// ----------------------------------------------------------------------------
// i2cm_front: input decode and decoupling queue
// Accepts input transfers, decodes the command and buffers the result in a
// small FIFO that feeds the bus engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front
  import i2cm_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire              clk,
  input  wire              rst_n,
  i2cm_chan_if.sink        in_ch,
  i2cm_chan_if.source      q_ch
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  cmd_t            q_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;
  cmd_t            dec;

  // Decode: first SDA level of each command
  always_comb begin
    dec.launch   = in_ch.data.cmd_valid;
    dec.op       = in_ch.data.op;
    dec.wr_data  = in_ch.data.wr_data;
    dec.send_ack = in_ch.data.send_ack;
    dec.sda_in   = in_ch.data.sda_in;
    case (in_ch.data.op)
      OP_STOP:  dec.first_sda = 1'b0;
      OP_WRITE: dec.first_sda = in_ch.data.wr_data[7];
      default:  dec.first_sda = 1'b1;
    endcase
  end

  assign in_ch.ready = (cnt_r != CntFull);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_ch.valid  = (cnt_r != '0);
  assign q_ch.data   = q_r[rd_ptr_r];
  assign pop         = q_ch.valid && q_ch.ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntFull)
    else $error("queue fill count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CntFull) && !pop |=> cnt_r == CntFull)
    else $error("queue full count dropped without a pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

/* hw/rtl/i2cm_engine.sv */
// ----------------------------------------------------------------------------
// i2cm_engine: bus sequencer and result register
// Steps the I2C phase machine once per queued item, counting microsecond
// waits with a prescaler, and holds each result until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_engine
  import i2cm_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire cfg_t        cfg,
  i2cm_chan_if.sink        q_ch,
  i2cm_chan_if.source      out_ch
);

  // Phase codes
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_ST_A      = 4'd1;
  localparam logic [3:0] PH_ST_B      = 4'd2;
  localparam logic [3:0] PH_SP_A      = 4'd3;
  localparam logic [3:0] PH_SP_B      = 4'd4;
  localparam logic [3:0] PH_SP_C      = 4'd5;
  localparam logic [3:0] PH_WR_SETUP  = 4'd6;
  localparam logic [3:0] PH_WR_HIGH   = 4'd7;
  localparam logic [3:0] PH_WR_LOW    = 4'd8;
  localparam logic [3:0] PH_WR_ASETUP = 4'd9;
  localparam logic [3:0] PH_WR_AHIGH  = 4'd10;
  localparam logic [3:0] PH_RD_HIGH   = 4'd11;
  localparam logic [3:0] PH_RD_LOW    = 4'd12;
  localparam logic [3:0] PH_RD_KSETUP = 4'd13;
  localparam logic [3:0] PH_RD_KHIGH  = 4'd14;

  logic [3:0] phase_r, phase_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [9:0] pres_r, pres_nxt;
  logic [7:0] dly_r, dly_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_r, ack_nxt;
  logic       pack_r, pack_nxt;
  logic [7:0] last_r, last_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r;
  out_item_t  res;

  logic       step;
  logic       fin;
  logic [9:0] cpu_eff;
  logic [9:0] pres_inc;
  logic       us_tick;
  logic [9:0] pres_cnt;
  logic [7:0] dly_cnt;
  logic [3:0] bit_inc;
  logic [7:0] short_ld;
  logic [7:0] long_ld;
  cmd_t       it;

  assign it       = q_ch.data;
  assign step     = q_ch.valid && q_ch.ready;
  assign q_ch.ready = !out_valid_r || out_ch.ready;

  // Zero registers act as one
  assign cpu_eff  = (cfg.cycles_per_us == '0) ? 10'd1 : cfg.cycles_per_us;
  assign short_ld = (cfg.short_delay_us == '0) ? 8'd1 : cfg.short_delay_us;
  assign long_ld  = (cfg.long_delay_us == '0) ? 8'd1 : cfg.long_delay_us;

  // Microsecond prescaler and wait countdown
  assign pres_inc = pres_r + 10'd1;
  assign us_tick  = (pres_inc >= cpu_eff);
  assign pres_cnt = us_tick ? '0 : pres_inc;
  assign dly_cnt  = (us_tick && dly_r != '0) ? dly_r - 8'd1 : dly_r;
  assign bit_inc  = bit_r + 4'd1;

  // Phase machine, one step per item
  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    dly_nxt   = dly_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    pack_nxt  = pack_r;
    last_nxt  = last_r;
    fin       = 1'b0;

    if (phase_r == PH_IDLE) begin
      // launch a command
      if (it.launch) begin
        pack_nxt = it.send_ack;
        bit_nxt  = '0;
        pres_nxt = '0;
        sda_nxt  = it.first_sda;
        case (it.op)
          OP_START: begin
            scl_nxt   = 1'b1;
            dly_nxt   = long_ld;
            phase_nxt = PH_ST_A;
          end
          OP_STOP: begin
            dly_nxt   = long_ld;
            phase_nxt = PH_SP_A;
          end
          OP_WRITE: begin
            shift_nxt = it.wr_data;
            dly_nxt   = short_ld;
            phase_nxt = PH_WR_SETUP;
          end
          default: begin
            shift_nxt = '0;
            scl_nxt   = 1'b1;
            dly_nxt   = long_ld;
            phase_nxt = PH_RD_HIGH;
          end
        endcase
      end
    end else begin
      pres_nxt = pres_cnt;
      dly_nxt  = dly_cnt;
      if (dly_cnt == '0) begin
        // wait over: move the bus lines; new waits restart the prescaler
        pres_nxt = '0;
        case (phase_r)
          PH_ST_A: begin
            sda_nxt = 1'b0; dly_nxt = long_ld; phase_nxt = PH_ST_B;
          end
          PH_ST_B: begin
            scl_nxt = 1'b0; fin = 1'b1;
          end
          PH_SP_A: begin
            scl_nxt = 1'b1; dly_nxt = long_ld; phase_nxt = PH_SP_B;
          end
          PH_SP_B: begin
            sda_nxt = 1'b1; dly_nxt = long_ld; phase_nxt = PH_SP_C;
          end
          PH_WR_SETUP: begin
            scl_nxt = 1'b1; dly_nxt = long_ld; phase_nxt = PH_WR_HIGH;
          end
          PH_WR_HIGH: begin
            scl_nxt = 1'b0; dly_nxt = short_ld; phase_nxt = PH_WR_LOW;
          end
          PH_WR_LOW: begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_inc;
            dly_nxt   = short_ld;
            if (bit_inc[3]) begin
              sda_nxt   = 1'b1;
              phase_nxt = PH_WR_ASETUP;
            end else begin
              sda_nxt   = shift_r[6];
              phase_nxt = PH_WR_SETUP;
            end
          end
          PH_WR_ASETUP: begin
            scl_nxt = 1'b1; dly_nxt = long_ld; phase_nxt = PH_WR_AHIGH;
          end
          PH_WR_AHIGH: begin
            ack_nxt = !it.sda_in; scl_nxt = 1'b0; fin = 1'b1;
          end
          PH_RD_HIGH: begin
            shift_nxt = {shift_r[6:0], it.sda_in};
            scl_nxt   = 1'b0;
            dly_nxt   = long_ld;
            phase_nxt = PH_RD_LOW;
          end
          PH_RD_LOW: begin
            bit_nxt = bit_inc;
            if (bit_inc[3]) begin
              sda_nxt   = !pack_r;
              dly_nxt   = short_ld;
              phase_nxt = PH_RD_KSETUP;
            end else begin
              scl_nxt   = 1'b1;
              dly_nxt   = long_ld;
              phase_nxt = PH_RD_HIGH;
            end
          end
          PH_RD_KSETUP: begin
            scl_nxt = 1'b1; dly_nxt = long_ld; phase_nxt = PH_RD_KHIGH;
          end
          PH_RD_KHIGH: begin
            scl_nxt = 1'b0; sda_nxt = 1'b1; last_nxt = shift_r; fin = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
        if (fin) begin
          phase_nxt = PH_IDLE;
          dly_nxt   = '0;
        end
      end
    end
  end

  // Result of this step
  always_comb begin
    res.scl_release  = scl_nxt;
    res.sda_release  = sda_nxt;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.done_res     = fin;
    res.rd_data      = last_nxt;
    res.ack_received = ack_nxt;
  end

  assign out_valid_nxt = step ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_r;

  // Control and bus state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_r       <= '0;
      shift_r     <= '0;
      pres_r      <= '0;
      dly_r       <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b0;
      pack_r      <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        pres_r  <= pres_nxt;
        dly_r   <= dly_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ack_r   <= ack_nxt;
        pack_r  <= pack_nxt;
        last_r  <= last_nxt;
      end
    end
  end

  // Result register, no reset
  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  a_wait_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (dly_r != '0))
    else $error("busy phase with no wait loaded");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (dly_r == '0 && pres_r == '0))
    else $error("idle with timing counters running");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= 4'd8)
    else $error("bit index past eight");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && fin |=> (phase_r == PH_IDLE) && !out_r.busy_res)
    else $error("finished command left engine busy");

endmodule

`default_nettype wire

/* hw/rtl/i2c_master_byte_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_byte_engine: open-drain I2C master, one bus cycle per item
// Each input transfer advances the bus by one clock cycle and yields exactly
// one result transfer with the line levels and command status.
//
//   channel | dir | payload    | notes
//   in_ch   | in  | in_item_t  | command, write byte, ack choice, SDA level
//   out_ch  | out | out_item_t | SCL/SDA release, busy, done, read byte, ack
//   cfg_*   | in  | 10b data   | write only: cycles/us, short and long wait
//
// One item per clock sustained while out_ch takes results; the engine steps
// its phase machine in the cycle an item leaves the queue and the result
// register frees as it drains. Input and output stall independently through
// a QUEUE_DEPTH entry queue. Synchronous active-low reset releases both lines
// and empties the queue. Items pass the queue, then the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine
  import i2cm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire                 clk,
  input  wire                 rst_n,
  i2cm_chan_if.sink           in_ch,
  i2cm_chan_if.source         out_ch,
  input  wire                 cfg_we,
  input  wire [CfgIdxW-1:0]   cfg_idx,
  input  wire [CfgDataW-1:0]  cfg_wdata
);

  cfg_t cfg_r;

  i2cm_chan_if #(.T(cmd_t)) q_ch ();

  // Timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cycles_per_us  <= CYCLES_PER_US_RST;
      cfg_r.short_delay_us <= SHORT_DELAY_RST;
      cfg_r.long_delay_us  <= LONG_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CYCLES_PER_US: cfg_r.cycles_per_us  <= cfg_wdata;
        CFG_SHORT_DELAY:   cfg_r.short_delay_us <= cfg_wdata[7:0];
        CFG_LONG_DELAY:    cfg_r.long_delay_us  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  i2cm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_ch  (q_ch.source)
  );

  i2cm_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_ch   (q_ch.sink),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

/* verif/i2c_master_byte_engine_test.sv */
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_test: self-checking bench for the I2C byte engine
// Each input transfer is one bus clock cycle. A cycle-accurate model of the
// phase machine predicts the line levels and status of every result, which
// are checked in order. A short command table runs first, then random
// command streams under several timing settings and idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_byte_engine_test;
  import i2cm_pkg::*;

  // Bus phases of the model
  typedef enum logic [4:0] {
    BUS_IDLE, START_SETUP, START_HOLD, STOP_SETUP, STOP_CLK_HIGH, STOP_DATA_HIGH,
    WR_SETUP, WR_HIGH, WR_LOW, WR_ACK_SETUP, WR_ACK_HIGH,
    RD_HIGH, RD_LOW, RD_ACK_SETUP, RD_ACK_HIGH
  } bus_phase_e;

  typedef enum logic {ROW_CYCLE, ROW_REG} row_kind_e;

  // One line of the directed command table
  typedef struct {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [9:0]  reg_val;
    in_item_t    cycle;
    logic        run_out;  // keep clocking until the command has finished
    logic        typed;    // use the written result instead of the model
    out_item_t   want;
  } plan_row_t;

  localparam int unsigned SECTIONS      = 8;
  localparam int unsigned SECTION_ITEMS = 80;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned REPORT_LIMIT  = 10;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  i2cm_chan_if #(.T(in_item_t))  in_ch ();
  i2cm_chan_if #(.T(out_item_t)) out_ch ();

  i2c_master_byte_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Model state and timing registers
  bus_phase_e bus_ph;
  logic [3:0] bit_cnt;
  logic [7:0] shift_reg;
  logic [9:0] us_tick;
  logic [7:0] wait_left;
  logic       scl_lvl, sda_lvl, ack_flag, cur_ack, cmd_done;
  logic [1:0] cur_op;
  logic [7:0] read_byte;
  logic [9:0] cfg_cpu;
  logic [7:0] cfg_short, cfg_long;

  out_item_t   pending_levels[$];
  plan_row_t   plan_q[$];
  int unsigned mismatches;
  int unsigned tx_idle_pct, rx_stall_pct;
  int unsigned rx_hold;

  // Clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("i2c_master_byte_engine: mismatch");
    $finish;
  end

  function automatic out_item_t bus_out(logic scl, logic sda, logic busy, logic done,
                                        logic [7:0] rd, logic ack);
    out_item_t r;
    r.scl_release  = scl;
    r.sda_release  = sda;
    r.busy_res     = busy;
    r.done_res     = done;
    r.rd_data      = rd;
    r.ack_received = ack;
    return r;
  endfunction

  function automatic void reset_bus_model();
    cfg_cpu   = CYCLES_PER_US_RST;
    cfg_short = SHORT_DELAY_RST;
    cfg_long  = LONG_DELAY_RST;
    bus_ph    = BUS_IDLE;
    bit_cnt   = '0;
    shift_reg = '0;
    us_tick   = '0;
    wait_left = '0;
    scl_lvl   = 1'b1;
    sda_lvl   = 1'b1;
    ack_flag  = 1'b0;
    cur_op    = OP_START;
    cur_ack   = 1'b0;
    read_byte = '0;
    cmd_done  = 1'b0;
  endfunction

  // A zero delay counts as one microsecond
  function automatic void load_wait(logic [7:0] us);
    wait_left = (us == 8'd0) ? 8'd1 : us;
    us_tick   = '0;
  endfunction

  function automatic void end_cmd();
    bus_ph    = BUS_IDLE;
    wait_left = '0;
    us_tick   = '0;
    cmd_done  = 1'b1;
  endfunction

  function automatic void launch_cmd(in_item_t it);
    cur_op  = it.op;
    cur_ack = it.send_ack;
    bit_cnt = '0;
    case (it.op)
      OP_START: begin
        sda_lvl = 1'b1;
        scl_lvl = 1'b1;
        load_wait(cfg_long);
        bus_ph = START_SETUP;
      end
      OP_STOP: begin
        sda_lvl = 1'b0;
        load_wait(cfg_long);
        bus_ph = STOP_SETUP;
      end
      OP_WRITE: begin
        shift_reg = it.wr_data;
        sda_lvl   = it.wr_data[7];
        load_wait(cfg_short);
        bus_ph = WR_SETUP;
      end
      default: begin
        shift_reg = '0;
        sda_lvl   = 1'b1;
        scl_lvl   = 1'b1;
        load_wait(cfg_long);
        bus_ph = RD_HIGH;
      end
    endcase
  endfunction

  // Step to the next phase once the current wait has run out
  function automatic void advance_phase(logic sda_in);
    case (bus_ph)
      START_SETUP: begin
        sda_lvl = 1'b0;
        load_wait(cfg_long);
        bus_ph = START_HOLD;
      end
      START_HOLD: begin
        scl_lvl = 1'b0;
        end_cmd();
      end
      STOP_SETUP: begin
        scl_lvl = 1'b1;
        load_wait(cfg_long);
        bus_ph = STOP_CLK_HIGH;
      end
      STOP_CLK_HIGH: begin
        sda_lvl = 1'b1;
        load_wait(cfg_long);
        bus_ph = STOP_DATA_HIGH;
      end
      WR_SETUP: begin
        scl_lvl = 1'b1;
        load_wait(cfg_long);
        bus_ph = WR_HIGH;
      end
      WR_HIGH: begin
        scl_lvl = 1'b0;
        load_wait(cfg_short);
        bus_ph = WR_LOW;
      end
      WR_LOW: begin
        shift_reg = shift_reg << 1;
        bit_cnt   = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          sda_lvl = 1'b1;
          load_wait(cfg_short);
          bus_ph = WR_ACK_SETUP;
        end else begin
          sda_lvl = shift_reg[7];
          load_wait(cfg_short);
          bus_ph = WR_SETUP;
        end
      end
      WR_ACK_SETUP: begin
        scl_lvl = 1'b1;
        load_wait(cfg_long);
        bus_ph = WR_ACK_HIGH;
      end
      WR_ACK_HIGH: begin
        // slave ack is the SDA level in the last cycle of the clock high
        ack_flag = !sda_in;
        scl_lvl  = 1'b0;
        end_cmd();
      end
      RD_HIGH: begin
        shift_reg = {shift_reg[6:0], sda_in};
        scl_lvl   = 1'b0;
        load_wait(cfg_long);
        bus_ph = RD_LOW;
      end
      RD_LOW: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          sda_lvl = !cur_ack;
          load_wait(cfg_short);
          bus_ph = RD_ACK_SETUP;
        end else begin
          scl_lvl = 1'b1;
          load_wait(cfg_long);
          bus_ph = RD_HIGH;
        end
      end
      RD_ACK_SETUP: begin
        scl_lvl = 1'b1;
        load_wait(cfg_long);
        bus_ph = RD_ACK_HIGH;
      end
      RD_ACK_HIGH: begin
        scl_lvl   = 1'b0;
        sda_lvl   = 1'b1;
        read_byte = shift_reg;
        end_cmd();
      end
      default: end_cmd();
    endcase
  endfunction

  // One bus clock cycle of the engine; commands while busy are dropped
  function automatic out_item_t predict_bus_cycle(in_item_t it);
    logic [9:0] cpu;
    cpu      = (cfg_cpu == 10'd0) ? 10'd1 : cfg_cpu;
    cmd_done = 1'b0;
    if (bus_ph == BUS_IDLE) begin
      if (it.cmd_valid) launch_cmd(it);
    end else begin
      us_tick = us_tick + 10'd1;
      if (us_tick >= cpu) begin
        us_tick = '0;
        if (wait_left != 8'd0) wait_left = wait_left - 8'd1;
      end
      if (wait_left == 8'd0) advance_phase(it.sda_in);
    end
    return bus_out(scl_lvl, sda_lvl, bus_ph != BUS_IDLE, cmd_done, read_byte, ack_flag);
  endfunction

  function automatic in_item_t bus_cycle(logic cmd, logic [1:0] op, logic [7:0] data,
                                         logic ack, logic sda);
    in_item_t it;
    it.cmd_valid = cmd;
    it.op        = op;
    it.wr_data   = data;
    it.send_ack  = ack;
    it.sda_in    = sda;
    return it;
  endfunction

  function automatic void plan_cycle(in_item_t it, logic run_out, logic typed,
                                     out_item_t want);
    plan_row_t r;
    r.kind    = ROW_CYCLE;
    r.reg_idx = CFG_CYCLES_PER_US;
    r.reg_val = '0;
    r.cycle   = it;
    r.run_out = run_out;
    r.typed   = typed;
    r.want    = want;
    plan_q.push_back(r);
  endfunction

  function automatic void plan_reg(logic [1:0] idx, logic [9:0] val);
    plan_row_t r;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    r.cycle   = '0;
    r.run_out = 1'b0;
    r.typed   = 1'b0;
    r.want    = '0;
    plan_q.push_back(r);
  endfunction

  // Random cycle: commands mostly when the bus is free, a few dropped ones
  function automatic in_item_t random_cycle();
    in_item_t it;
    it.op       = 2'($urandom_range(3));
    it.wr_data  = 8'($urandom_range(255));
    it.send_ack = 1'($urandom_range(1));
    it.sda_in   = 1'($urandom_range(1));
    if (bus_ph == BUS_IDLE) it.cmd_valid = ($urandom_range(99) < 70);
    else it.cmd_valid = ($urandom_range(99) < 8);
    return it;
  endfunction

  // Offer one cycle; entered and left at a falling edge
  task automatic send_cycle(in_item_t it, logic typed, out_item_t want);
    out_item_t pred;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_bus_cycle(it);
    pending_levels.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_levels.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CYCLES_PER_US: cfg_cpu   = val;
      CFG_SHORT_DELAY:   cfg_short = val[7:0];
      CFG_LONG_DELAY:    cfg_long  = val[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      out_ch.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_bus_levels
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_levels.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: result transfer with nothing expected (scl %b sda %b busy %b)",
                   $time, got.scl_release, got.sda_release, got.busy_res);
        mismatches++;
      end else begin
        want = pending_levels.pop_front();
        if (got.scl_release !== want.scl_release || got.sda_release !== want.sda_release ||
            got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
            got.rd_data !== want.rd_data || got.ack_received !== want.ack_received) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: expected scl %b sda %b busy %b done %b rd %h ack %b", $time,
                     want.scl_release, want.sda_release, want.busy_res, want.done_res,
                     want.rd_data, want.ack_received);
            $display("%0t: actual   scl %b sda %b busy %b done %b rd %h ack %b", $time,
                     got.scl_release, got.sda_release, got.busy_res, got.done_res,
                     got.rd_data, got.ack_received);
          end
          mismatches++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    plan_row_t row;
    in_item_t  it;
    int unsigned sec;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    mismatches   = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold      = 0;
    reset_bus_model();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: reset timing, then fast timing, zero registers,
    // maximum registers and a change of timing in the middle of a wait
    plan_cycle(bus_cycle(1'b0, OP_START, 8'h00, 1'b0, 1'b1), 1'b0, 1'b1,
               bus_out(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0));
    plan_cycle(bus_cycle(1'b1, OP_START, 8'h00, 1'b0, 1'b1), 1'b0, 1'b1,
               bus_out(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
    // write offered while busy is dropped
    plan_cycle(bus_cycle(1'b1, OP_WRITE, 8'hFF, 1'b1, 1'b1), 1'b0, 1'b1,
               bus_out(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
    plan_reg(CFG_CYCLES_PER_US, 10'd1);
    plan_reg(CFG_LONG_DELAY, 10'd1);
    plan_reg(CFG_SHORT_DELAY, 10'd1);
    plan_cycle(bus_cycle(1'b0, OP_READ, 8'h00, 1'b0, 1'b1), 1'b1, 1'b0, '0);
    plan_cycle(bus_cycle(1'b1, OP_WRITE, 8'h00, 1'b0, 1'b0), 1'b1, 1'b0, '0);
    plan_cycle(bus_cycle(1'b1, OP_WRITE, 8'hFF, 1'b1, 1'b1), 1'b1, 1'b0, '0);
    plan_cycle(bus_cycle(1'b1, OP_READ, 8'hFF, 1'b1, 1'b1), 1'b1, 1'b0, '0);
    plan_cycle(bus_cycle(1'b1, OP_READ, 8'h00, 1'b0, 1'b0), 1'b1, 1'b0, '0);
    plan_cycle(bus_cycle(1'b1, OP_WRITE, 8'hA5, 1'b0, 1'b0), 1'b1, 1'b0, '0);
    plan_cycle(bus_cycle(1'b1, OP_STOP, 8'h5A, 1'b1, 1'b1), 1'b1, 1'b0, '0);
    plan_reg(CFG_CYCLES_PER_US, 10'd0);
    plan_reg(CFG_SHORT_DELAY, 10'd0);
    plan_reg(CFG_LONG_DELAY, 10'd0);
    plan_cycle(bus_cycle(1'b1, OP_START, 8'h00, 1'b0, 1'b1), 1'b1, 1'b0, '0);
    plan_cycle(bus_cycle(1'b1, OP_READ, 8'h3C, 1'b1, 1'b0), 1'b1, 1'b0, '0);
    plan_reg(CFG_CYCLES_PER_US, 10'd1023);
    plan_reg(CFG_LONG_DELAY, 10'd255);
    plan_reg(CFG_SHORT_DELAY, 10'd255);
    plan_cycle(bus_cycle(1'b1, OP_STOP, 8'h00, 1'b0, 1'b0), 1'b0, 1'b0, '0);
    plan_cycle(bus_cycle(1'b0, OP_START, 8'h00, 1'b0, 1'b1), 1'b0, 1'b0, '0);
    // shorten timing while the stop waits out its first delay
    plan_reg(CFG_CYCLES_PER_US, 10'd1);
    plan_reg(CFG_LONG_DELAY, 10'd1);
    plan_reg(CFG_SHORT_DELAY, 10'd1);
    plan_cycle(bus_cycle(1'b0, OP_READ, 8'h00, 1'b0, 1'b1), 1'b1, 1'b0, '0);

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_cycle(row.cycle, row.typed, row.want);
        // finish the command, offering dropped commands on the way
        it = row.cycle;
        it.cmd_valid = 1'b1;
        while (row.run_out && bus_ph != BUS_IDLE) send_cycle(it, 1'b0, '0);
      end
    end

    // Random command streams over several timings and idling phases
    for (sec = 0; sec < SECTIONS; sec++) begin
      write_reg(CFG_CYCLES_PER_US, 10'($urandom_range(3)));
      write_reg(CFG_SHORT_DELAY, 10'($urandom_range(3)));
      write_reg(CFG_LONG_DELAY, 10'($urandom_range(4)));
      case (sec % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      if (sec == 0) begin
        // long receiver hold-off while cycles keep coming
        @(posedge clk);
        rx_hold = HOLD_CYCLES;
        @(negedge clk);
      end
      repeat (SECTION_ITEMS) send_cycle(random_cycle(), 1'b0, '0);
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("i2c_master_byte_engine: match");
    end else begin
      $display("i2c_master_byte_engine: mismatch");
    end
    $finish;
  end

endmodule
